[rtl/ycck_pkg.sv]
package ycck_pkg;

  localparam int CFG_DATA_W = 15;

  typedef enum logic [2:0] {
    REG_KEY_CB       = 3'd0,
    REG_KEY_CR       = 3'd1,
    REG_ACCEPT_TAN   = 3'd2,
    REG_ACCEPT_COTAN = 3'd3,
    REG_INV_GAIN     = 3'd4,
    REG_LUMA_SUPP    = 3'd5,
    REG_NOISE_THR    = 3'd6,
    REG_BLANK        = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic signed [7:0] key_cb;
    logic signed [7:0] key_cr;
    logic [9:0]        accept_tan;
    logic [10:0]       accept_cotan;
    logic signed [8:0] inv_gain;
    logic [11:0]       luma_supp;
    logic [14:0]       noise_thr;
    logic              blank;
  } cfg_t;

  localparam logic signed [7:0] RST_KEY_CB       = 8'sd0;
  localparam logic signed [7:0] RST_KEY_CR       = 8'sd127;
  localparam logic [9:0]        RST_ACCEPT_TAN   = 10'd15;
  localparam logic [10:0]       RST_ACCEPT_COTAN = 11'd15;
  localparam logic signed [8:0] RST_INV_GAIN     = -9'sd255;
  localparam logic [11:0]       RST_LUMA_SUPP    = 12'd0;
  localparam logic [14:0]       RST_NOISE_THR    = 15'd0;
  localparam logic              RST_BLANK        = 1'b1;

endpackage

[rtl/ycbcr_chroma_keyer_top.sv]
// A pixel taken with start high and busy low passes through stages 1 to 8
// and shows on the registered outputs, marked by done.
// Throughput: one pixel per clock; eight multiply and add stages in flight.
// busy is high only during reset. The result is held for one cycle only,
// the receiver cannot stall. rst clears the pipeline and loads the
// default key set-up.
module ycbcr_chroma_keyer_top
  import ycck_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  write_enable,
  input  logic [2:0]            reg_index,
  input  logic [CFG_DATA_W-1:0] write_data,
  input  logic [7:0]            fore_luma,
  input  logic [7:0]            fore_blue_diff,
  input  logic [7:0]            fore_red_diff,
  input  logic [7:0]            back_luma,
  input  logic [7:0]            back_blue_diff,
  input  logic [7:0]            back_red_diff,
  input  logic                  last_in_frame,
  output logic                  done,
  output logic [7:0]            out_luma,
  output logic [7:0]            out_blue_diff,
  output logic [7:0]            out_red_diff,
  output logic                  was_keyed,
  output logic                  last_out
);

  typedef struct packed {
    logic [7:0] fy;
    logic [7:0] fcb;
    logic [7:0] fcr;
    logic [7:0] by;
    logic [7:0] bcb;
    logic [7:0] bcr;
    logic       last;
  } pix_t;

  cfg_t cfg;

  ycck_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .cfg          (cfg)
  );

  assign busy = rst;

  function automatic logic signed [7:0] sat8(input logic signed [9:0] v);
    if (v > 10'sd127) begin
      return 8'sd127;
    end else if (v < -10'sd128) begin
      return -8'sd128;
    end
    return v[7:0];
  endfunction

  logic [7:0] vld;
  pix_t pix1, pix2, pix3, pix4, pix5, pix6, pix7;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[6:0], start & ~busy};
    end
  end

  // stage 1: rotation products on centred chroma
  logic signed [7:0]  fcb_in, fcr_in;
  logic signed [15:0] pxa, pxb, pya, pyb;

  assign fcb_in = $signed({~fore_blue_diff[7], fore_blue_diff[6:0]});
  assign fcr_in = $signed({~fore_red_diff[7], fore_red_diff[6:0]});

  always_ff @(posedge clk) begin
    pix1 <= '{fore_luma, fore_blue_diff, fore_red_diff, back_luma, back_blue_diff,
              back_red_diff, last_in_frame};
    pxa  <= 16'(fcb_in) * 16'(cfg.key_cb);
    pxb  <= 16'(fcr_in) * 16'(cfg.key_cr);
    pya  <= 16'(fcr_in) * 16'(cfg.key_cb);
    pyb  <= 16'(fcb_in) * 16'(cfg.key_cr);
  end

  // stage 2: xx, yy
  logic signed [16:0] sx_next, sy_next;
  logic signed [7:0]  xx2, yy2;

  assign sx_next = $signed({pxa[15], pxa}) + $signed({pxb[15], pxb});
  assign sy_next = $signed({pya[15], pya}) - $signed({pyb[15], pyb});

  always_ff @(posedge clk) begin
    pix2 <= pix1;
    xx2  <= sat8(sx_next[16:7]);
    yy2  <= sat8(sy_next[16:7]);
  end

  // stage 3: limit, cotangent and noise products
  logic signed [18:0] lim_p3;
  logic signed [19:0] ctg_p3;
  logic signed [15:0] yysq_next;
  logic [14:0]        yysq3;
  logic signed [7:0]  xx3, yy3;

  assign yysq_next = 16'(yy2) * 16'(yy2);

  always_ff @(posedge clk) begin
    pix3   <= pix2;
    lim_p3 <= 19'(xx2) * 19'($signed({1'b0, cfg.accept_tan}));
    ctg_p3 <= 20'(yy2) * 20'($signed({1'b0, cfg.accept_cotan}));
    yysq3  <= yysq_next[14:0];
    xx3    <= xx2;
    yy3    <= yy2;
  end

  // stage 4: accept test, x1, d
  logic signed [14:0] limv_next, lim_next;
  logic [7:0]         absyy_next;
  logic signed [15:0] q_next;
  logic [14:0]        x1_next;
  logic signed [15:0] d_next;
  logic               keyed4, noise4;
  logic [14:0]        x14;
  logic signed [15:0] d4;
  logic signed [7:0]  yy4;

  assign limv_next  = lim_p3[18:4];
  assign lim_next   = (limv_next > 15'sd127) ? 15'sd127 : limv_next;
  assign absyy_next = yy3[7] ? 8'(~yy3 + 8'sd1) : yy3;
  assign q_next     = ctg_p3[19:4];
  assign x1_next    = q_next[15] ? 15'(-q_next) : q_next[14:0];
  assign d_next     = $signed({{8{xx3[7]}}, xx3}) - $signed({1'b0, x1_next});

  always_ff @(posedge clk) begin
    pix4   <= pix3;
    keyed4 <= $signed({7'b0, absyy_next}) < lim_next;
    noise4 <= yysq3 < cfg.noise_thr;
    x14    <= x1_next;
    d4     <= d_next;
    yy4    <= yy3;
  end

  // stage 5: weight, suppression and inverse rotation products
  logic signed [24:0] kp5;
  logic signed [28:0] sp5;
  logic signed [23:0] m15, m35;
  logic signed [15:0] m25, m45;
  logic               keyed5, noise5;
  logic signed [15:0] x1s;

  assign x1s = $signed({1'b0, x14});

  always_ff @(posedge clk) begin
    pix5   <= pix4;
    kp5    <= 25'(d4) * 25'(cfg.inv_gain);
    sp5    <= 29'(d4) * 29'($signed({1'b0, cfg.luma_supp}));
    m15    <= 24'(x1s) * 24'(cfg.key_cb);
    m25    <= 16'(yy4) * 16'(cfg.key_cr);
    m35    <= 24'(x1s) * 24'(cfg.key_cr);
    m45    <= 16'(yy4) * 16'(cfg.key_cb);
    keyed5 <= keyed4;
    noise5 <= noise4;
  end

  // stage 6: kbg, suppressed foreground, noise override
  logic signed [23:0] kv_next;
  logic signed [24:0] sv_next, sup_next, dcb_next, dcr_next;
  logic [7:0]         kbg_next;
  logic signed [25:0] fy_next;
  logic signed [17:0] scb_next, scr_next;
  logic [7:0]         kbg6;
  logic signed [25:0] fy6;
  logic signed [17:0] scb6, scr6;
  logic               keyed6;

  assign kv_next  = kp5[24:1];
  assign sv_next  = sp5[28:4];
  assign sup_next = (sv_next > 25'sd255) ? 25'sd255 : sv_next;
  assign dcb_next = $signed({m15[23], m15}) - $signed({{9{m25[15]}}, m25});
  assign dcr_next = $signed({m35[23], m35}) + $signed({{9{m45[15]}}, m45});

  always_comb begin
    if (kv_next[23]) begin
      kbg_next = 8'd0;
    end else if (kv_next > 24'sd255) begin
      kbg_next = 8'd255;
    end else begin
      kbg_next = kv_next[7:0];
    end
    fy_next  = $signed({18'b0, pix5.fy}) - $signed({sup_next[24], sup_next});
    scb_next = dcb_next[24:7];
    scr_next = dcr_next[24:7];
    if (noise5) begin
      kbg_next = 8'd255;
      if (cfg.blank) begin
        fy_next  = '0;
        scb_next = '0;
        scr_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pix6   <= pix5;
    kbg6   <= kbg_next;
    fy6    <= fy_next;
    scb6   <= scb_next;
    scr6   <= scr_next;
    keyed6 <= keyed5;
  end

  // stage 7: background scaling
  logic [15:0]        byp7;
  logic signed [16:0] bcbp7, bcrp7;
  logic signed [25:0] fy7;
  logic signed [17:0] scb7, scr7;
  logic               keyed7;

  always_ff @(posedge clk) begin
    pix7   <= pix6;
    byp7   <= 16'(kbg6) * 16'(pix6.by);
    bcbp7  <= 17'($signed({1'b0, kbg6})) * 17'($signed({~pix6.bcb[7], pix6.bcb[6:0]}));
    bcrp7  <= 17'($signed({1'b0, kbg6})) * 17'($signed({~pix6.bcr[7], pix6.bcr[6:0]}));
    fy7    <= fy6;
    scb7   <= scb6;
    scr7   <= scr6;
    keyed7 <= keyed6;
  end

  // stage 8: blend, clamp, select
  logic signed [26:0] ys_next;
  logic signed [19:0] cbs_next, crs_next;
  logic [7:0]         oy_next, ocb_next, ocr_next;

  assign ys_next  = $signed({fy7[25], fy7}) + $signed({19'b0, byp7[15:8]});
  assign cbs_next = 20'sd128 + $signed({{2{scb7[17]}}, scb7})
                  + $signed({{11{bcbp7[16]}}, bcbp7[16:8]});
  assign crs_next = 20'sd128 + $signed({{2{scr7[17]}}, scr7})
                  + $signed({{11{bcrp7[16]}}, bcrp7[16:8]});

  always_comb begin
    if (ys_next < 27'sd16) begin
      oy_next = 8'd16;
    end else if (ys_next > 27'sd235) begin
      oy_next = 8'd235;
    end else begin
      oy_next = ys_next[7:0];
    end
    if (cbs_next < 20'sd16) begin
      ocb_next = 8'd16;
    end else if (cbs_next > 20'sd240) begin
      ocb_next = 8'd240;
    end else begin
      ocb_next = cbs_next[7:0];
    end
    if (crs_next < 20'sd16) begin
      ocr_next = 8'd16;
    end else if (crs_next > 20'sd240) begin
      ocr_next = 8'd240;
    end else begin
      ocr_next = crs_next[7:0];
    end
  end

  always_ff @(posedge clk) begin
    out_luma      <= keyed7 ? oy_next : pix7.fy;
    out_blue_diff <= keyed7 ? ocb_next : pix7.fcb;
    out_red_diff  <= keyed7 ? ocr_next : pix7.fcr;
    was_keyed     <= keyed7;
    last_out      <= pix7.last;
  end

  assign done = vld[7];

endmodule

[rtl/ycck_cfg.sv]
module ycck_cfg
  import ycck_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  write_enable,
  input  logic [2:0]            reg_index,
  input  logic [CFG_DATA_W-1:0] write_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_cb       <= RST_KEY_CB;
      cfg.key_cr       <= RST_KEY_CR;
      cfg.accept_tan   <= RST_ACCEPT_TAN;
      cfg.accept_cotan <= RST_ACCEPT_COTAN;
      cfg.inv_gain     <= RST_INV_GAIN;
      cfg.luma_supp    <= RST_LUMA_SUPP;
      cfg.noise_thr    <= RST_NOISE_THR;
      cfg.blank        <= RST_BLANK;
    end else if (write_enable) begin
      case (reg_index_t'(reg_index))
        REG_KEY_CB:       cfg.key_cb       <= write_data[7:0];
        REG_KEY_CR:       cfg.key_cr       <= write_data[7:0];
        REG_ACCEPT_TAN:   cfg.accept_tan   <= write_data[9:0];
        REG_ACCEPT_COTAN: cfg.accept_cotan <= write_data[10:0];
        REG_INV_GAIN:     cfg.inv_gain     <= write_data[8:0];
        REG_LUMA_SUPP:    cfg.luma_supp    <= write_data[11:0];
        REG_NOISE_THR:    cfg.noise_thr    <= write_data[14:0];
        REG_BLANK:        cfg.blank        <= write_data[0];
        default: ;
      endcase
    end
  end

endmodule

[tb/keyer_tb_pkg.sv]
`timescale 1ns / 100ps
package keyer_tb_pkg;
  import ycck_pkg::*;

  typedef struct packed {
    logic [7:0] fore_y;
    logic [7:0] fore_cb;
    logic [7:0] fore_cr;
    logic [7:0] back_y;
    logic [7:0] back_cb;
    logic [7:0] back_cr;
    logic       last;
  } pixel_t;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] cb;
    logic [7:0] cr;
    logic       keyed;
    logic       last;
  } keyed_pixel_t;

  class keyer_scoreboard;
    int key_cb, key_cr, tan15, cot15, bg_gain, luma_supp, noise_thr, blank_fg;
    keyed_pixel_t pending[$];
    int mismatches;
    int checked;
    int keyed_seen;

    function new();
      key_cb    = RST_KEY_CB;
      key_cr    = RST_KEY_CR;
      tan15     = RST_ACCEPT_TAN;
      cot15     = RST_ACCEPT_COTAN;
      bg_gain   = RST_INV_GAIN;
      luma_supp = RST_LUMA_SUPP;
      noise_thr = RST_NOISE_THR;
      blank_fg  = RST_BLANK;
    endfunction

    static function int clamp(int v, int lo, int hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_KEY_CB:       key_cb    = $signed(v[7:0]);
        REG_KEY_CR:       key_cr    = $signed(v[7:0]);
        REG_ACCEPT_TAN:   tan15     = v[9:0];
        REG_ACCEPT_COTAN: cot15     = v[10:0];
        REG_INV_GAIN:     bg_gain   = $signed(v[8:0]);
        REG_LUMA_SUPP:    luma_supp = v[11:0];
        REG_NOISE_THR:    noise_thr = v[14:0];
        REG_BLANK:        blank_fg  = v[0];
        default: ;
      endcase
    endfunction

    // Accept-angle key of one pixel; >>> on int is a floor shift.
    function keyed_pixel_t key_pixel(pixel_t p);
      int fcb, fcr, xx, yy, lim, x1, d, kbg, sup, fy, scb, scr;
      keyed_pixel_t r;
      r = {p.fore_y, p.fore_cb, p.fore_cr, 1'b0, p.last};
      fcb = int'(p.fore_cb) - 128;
      fcr = int'(p.fore_cr) - 128;
      xx = clamp((fcb * key_cb + fcr * key_cr) >>> 7, -128, 127);
      yy = clamp((fcr * key_cb - fcb * key_cr) >>> 7, -128, 127);
      lim = (xx * tan15) >>> 4;
      if (lim > 127) lim = 127;
      if ((yy < 0 ? -yy : yy) < lim) begin
        x1 = (yy * cot15) >>> 4;
        if (x1 < 0) x1 = -x1;
        d = xx - x1;
        kbg = clamp((d * bg_gain) >>> 1, 0, 255);
        sup = (d * luma_supp) >>> 4;
        if (sup > 255) sup = 255;
        fy = int'(p.fore_y) - sup;
        scb = (x1 * key_cb - yy * key_cr) >>> 7;
        scr = (x1 * key_cr + yy * key_cb) >>> 7;
        if (yy * yy < noise_thr) begin
          kbg = 255;
          if (blank_fg != 0) begin
            fy = 0;
            scb = 0;
            scr = 0;
          end
        end
        r.y = 8'(clamp(fy + ((kbg * int'(p.back_y)) >>> 8), 16, 235));
        r.cb = 8'(clamp(128 + scb + ((kbg * (int'(p.back_cb) - 128)) >>> 8), 16, 240));
        r.cr = 8'(clamp(128 + scr + ((kbg * (int'(p.back_cr) - 128)) >>> 8), 16, 240));
        r.keyed = 1'b1;
      end
      return r;
    endfunction

    function void note_pixel(pixel_t p);
      pending.push_back(key_pixel(p));
    endfunction

    function int field_diff(string name, int want, int got);
      if (want == got) return 0;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1;
    endfunction

    function void check_result(keyed_pixel_t got);
      keyed_pixel_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with no pending transaction, actual y=%0d cb=%0d cr=%0d",
                 $time, got.y, got.cb, got.cr);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      mismatches += field_diff("out_luma", want.y, got.y);
      mismatches += field_diff("out_blue_diff", want.cb, got.cb);
      mismatches += field_diff("out_red_diff", want.cr, got.cr);
      mismatches += field_diff("was_keyed", want.keyed, got.keyed);
      mismatches += field_diff("last_out", want.last, got.last);
      if (want.keyed) keyed_seen++;
      checked++;
    endfunction
  endclass

endpackage

[tb/tb.sv]
`timescale 1ns / 100ps
module tb;
  import ycck_pkg::*;
  import keyer_tb_pkg::*;

  localparam int LATENCY = 8;
  localparam int STALL_LIMIT = 500;
  localparam int PHASE_ITEMS = 106;

  localparam pixel_t CORNERS[12] = '{
    {8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0},
    {8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1},
    {8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 1'b0},
    {8'd100, 8'd128, 8'd255, 8'd200, 8'd40,  8'd220, 1'b0},
    {8'd100, 8'd128, 8'd0,   8'd200, 8'd40,  8'd220, 1'b0},
    {8'd235, 8'd255, 8'd0,   8'd255, 8'd255, 8'd0,   1'b1},
    {8'd16,  8'd0,   8'd255, 8'd0,   8'd0,   8'd255, 1'b0},
    {8'd50,  8'd150, 8'd240, 8'd255, 8'd0,   8'd255, 1'b0},
    {8'd200, 8'd110, 8'd250, 8'd0,   8'd255, 8'd0,   1'b1},
    {8'd255, 8'd128, 8'd200, 8'd255, 8'd255, 8'd255, 1'b0},
    {8'd0,   8'd140, 8'd255, 8'd255, 8'd128, 8'd0,   1'b0},
    {8'd128, 8'd200, 8'd20,  8'd128, 8'd255, 8'd255, 1'b1}
  };

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic                  write_enable;
  logic [2:0]            reg_index;
  logic [CFG_DATA_W-1:0] write_data;
  logic [7:0]            fore_luma, fore_blue_diff, fore_red_diff;
  logic [7:0]            back_luma, back_blue_diff, back_red_diff;
  logic                  last_in_frame;
  logic                  done;
  logic [7:0]            out_luma, out_blue_diff, out_red_diff;
  logic                  was_keyed;
  logic                  last_out;

  keyer_scoreboard sb = new();
  cfg_t cur_cfg;
  int   quiet_cycles = 0;
  int   phases_run = 0;
  bit   zero_gap_run = 1'b0;

  ycbcr_chroma_keyer_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (start && !busy)
      sb.note_pixel({fore_luma, fore_blue_diff, fore_red_diff,
                     back_luma, back_blue_diff, back_red_diff, last_in_frame});
    if (done)
      sb.check_result({out_luma, out_blue_diff, out_red_diff, was_keyed, last_out});
    if ((start && !busy) || done || write_enable)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog, no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic cfg_t make_cfg(int kcb, int kcr, int tan, int cot, int gain,
                                    int lss, int noise, bit blank);
    cfg_t c;
    c.key_cb       = 8'(kcb);
    c.key_cr       = 8'(kcr);
    c.accept_tan   = 10'(tan);
    c.accept_cotan = 11'(cot);
    c.inv_gain     = 9'(gain);
    c.luma_supp    = 12'(lss);
    c.noise_thr    = 15'(noise);
    c.blank        = blank;
    return c;
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.key_cb       = 8'($urandom);
    c.key_cr       = 8'($urandom);
    c.accept_tan   = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(4, 60));
    c.accept_cotan = ($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'($urandom_range(0, 60));
    c.inv_gain     = 9'($urandom);
    c.luma_supp    = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 60));
    c.noise_thr    = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 2000));
    c.blank        = 1'($urandom);
    return c;
  endfunction

  // Mostly pixels near the key axis so the keyed path sees real traffic.
  function automatic pixel_t rand_pixel();
    pixel_t p;
    int m;
    p.fore_y  = 8'($urandom);
    p.back_y  = 8'($urandom);
    p.back_cb = 8'($urandom);
    p.back_cr = 8'($urandom);
    p.last    = ($urandom_range(0, 15) == 0);
    if ($urandom_range(0, 9) < 7) begin
      m = $urandom_range(0, 127);
      p.fore_cb = 8'(keyer_scoreboard::clamp(128 + (m * int'(cur_cfg.key_cb)) / 127
                     + int'($urandom_range(0, 40)) - 20, 0, 255));
      p.fore_cr = 8'(keyer_scoreboard::clamp(128 + (m * int'(cur_cfg.key_cr)) / 127
                     + int'($urandom_range(0, 40)) - 20, 0, 255));
    end else begin
      p.fore_cb = 8'($urandom);
      p.fore_cr = 8'($urandom);
    end
    return p;
  endfunction

  task automatic send_pixel(pixel_t p);
    int gap;
    if ($urandom_range(0, 19) == 0) zero_gap_run = !zero_gap_run;
    gap = zero_gap_run ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    fore_luma      <= p.fore_y;
    fore_blue_diff <= p.fore_cb;
    fore_red_diff  <= p.fore_cr;
    back_luma      <= p.back_y;
    back_blue_diff <= p.back_cb;
    back_red_diff  <= p.back_cr;
    last_in_frame  <= p.last;
    do @(posedge clk); while (busy);
  endtask

  task automatic put_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] v);
    write_enable <= 1'b1;
    reg_index    <= idx;
    write_data   <= v;
    sb.write_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic write_cfg(cfg_t c);
    put_reg(REG_KEY_CB, CFG_DATA_W'(c.key_cb));
    put_reg(REG_KEY_CR, CFG_DATA_W'(c.key_cr));
    put_reg(REG_ACCEPT_TAN, CFG_DATA_W'(c.accept_tan));
    put_reg(REG_ACCEPT_COTAN, CFG_DATA_W'(c.accept_cotan));
    put_reg(REG_INV_GAIN, CFG_DATA_W'(c.inv_gain));
    put_reg(REG_LUMA_SUPP, CFG_DATA_W'(c.luma_supp));
    put_reg(REG_NOISE_THR, c.noise_thr);
    put_reg(REG_BLANK, CFG_DATA_W'(c.blank));
    write_enable <= 1'b0;
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic run_phase(bit load, cfg_t c, bit corners, int n);
    settle();
    if (load) write_cfg(c);
    cur_cfg = c;
    if (corners)
      foreach (CORNERS[i]) send_pixel(CORNERS[i]);
    repeat (n) send_pixel(rand_pixel());
    phases_run++;
  endtask

  initial begin
    rst            <= 1'b1;
    start          <= 1'b0;
    write_enable   <= 1'b0;
    reg_index      <= REG_KEY_CB;
    write_data     <= '0;
    fore_luma      <= '0;
    fore_blue_diff <= '0;
    fore_red_diff  <= '0;
    back_luma      <= '0;
    back_blue_diff <= '0;
    back_red_diff  <= '0;
    last_in_frame  <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    run_phase(1'b0, make_cfg(RST_KEY_CB, RST_KEY_CR, RST_ACCEPT_TAN, RST_ACCEPT_COTAN,
                             RST_INV_GAIN, RST_LUMA_SUPP, RST_NOISE_THR, RST_BLANK),
              1'b1, PHASE_ITEMS);
    run_phase(1'b1, make_cfg(-90, -90, 15, 15, -251, 18, 64, 1'b1), 1'b0, PHASE_ITEMS);
    // noise always triggers, wide cotangent gives negative suppression
    run_phase(1'b1, make_cfg(127, -128, 1023, 2047, 255, 4095, 16385, 1'b0), 1'b1,
              PHASE_ITEMS);
    run_phase(1'b1, make_cfg(-128, -128, 0, 0, -256, 0, 0, 1'b0), 1'b0, PHASE_ITEMS);
    run_phase(1'b1, make_cfg(-127, 127, 1023, 0, -256, 4095, 32767, 1'b1), 1'b0,
              PHASE_ITEMS);
    repeat (3) run_phase(1'b1, rand_cfg(), 1'b0, PHASE_ITEMS);
    settle();

    $display("Checked %0d pixel transactions over %0d key set-ups, %0d of them keyed",
             sb.checked, phases_run, sb.keyed_seen);
    if (sb.pending.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, sb.pending.size());
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
